FILE: hw/rtl/ssdbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdbd_pkg
// Shared types, constants and table builders for the SSD box decoder with
// class confidence gate.
// ----------------------------------------------------------------------------
package ssdbd_pkg;

    // default table depths
    localparam int EXP_TABLE_DEPTH_DEF = 1024;
    localparam int SIG_TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DELTA_W     = 16;
    localparam int PRIOR_W     = 16;
    localparam int CLASS_W     = 8;
    localparam int LOGIT_W     = 16;
    localparam int SIZE_W      = 12;
    localparam int WEIGHT_W    = 16;
    localparam int BOX_W       = 20;
    localparam int SCORE_W     = 16;
    localparam int EXP_W       = 32;

    // internal datapath widths
    localparam int PROD_W   = 32;   // delta times weight
    localparam int CENTER_W = 49;   // center in Q.44
    localparam int HALF_W   = 48;   // exp entry times prior
    localparam int Q44_W    = 57;   // edge in Q.44
    localparam int Q24_W    = 37;   // edge in Q.24

    // register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOGIT_THRESHOLD = 3'd0,
        CFG_NUM_CLASSES     = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_CENTER_WEIGHT   = 3'd4,
        CFG_SIZE_WEIGHT     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit_threshold;
        logic [CLASS_W-1:0]        num_classes;
        logic [SIZE_W-1:0]         image_width;
        logic [SIZE_W-1:0]         image_height;
        logic [WEIGHT_W-1:0]       center_weight;
        logic [WEIGHT_W-1:0]       size_weight;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        logit_threshold: 16'sd0,
        num_classes:     8'd91,
        image_width:     12'd300,
        image_height:    12'd300,
        center_weight:   16'd6554,
        size_weight:     16'd13107
    };

    // table building, evaluated at elaboration only
    localparam longint ONE_Q30 = longint'(1) << 30;

    typedef struct packed {
        longint mant;
        int     ex;
    } exp_norm_t;

    // signed division truncating toward zero, shift and subtract
    function automatic longint div_trunc(input longint num, input longint den);
        longint unsigned un;
        longint unsigned ud;
        longint unsigned rem;
        longint unsigned quo;
        logic            neg;
        neg = (num < 0) != (den < 0);
        un  = unsigned'((num < 0) ? -num : num);
        ud  = unsigned'((den < 0) ? -den : den);
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[62:0], un[k]};
            if (rem >= ud) begin
                rem    = rem - ud;
                quo[k] = 1'b1;
            end
        end
        return neg ? -signed'(quo) : signed'(quo);
    endfunction

    // exp(r * 2^squarings) as mantissa in Q.30 times 2^ex
    function automatic exp_norm_t exp_build(input longint r, input int squarings);
        longint    term;
        longint    sum;
        longint    m;
        int        e;
        exp_norm_t res;
        term = ONE_Q30;
        sum  = ONE_Q30;
        e    = 0;
        for (int n = 1; n <= 17; n++) begin
            term = (term * r) / ONE_Q30;
            term = div_trunc(term, longint'(n));
            sum  = sum + term;
        end
        m = sum;
        if (m < (longint'(1) << 30)) begin
            m = m << 1;
            e = e - 1;
        end
        if (m >= (longint'(1) << 31)) begin
            m = (m + 1) >> 1;
            e = e + 1;
        end
        for (int n = 0; n < squarings; n++) begin
            m = (m * m + (longint'(1) << 29)) >> 30;
            e = e * 2;
            if (m >= (longint'(1) << 31)) begin
                m = (m + 1) >> 1;
                e = e + 1;
            end
        end
        res.mant = m;
        res.ex   = e;
        return res;
    endfunction

    // exp table entry, Q12.20 of exp(-8 + 16 idx / depth)
    function automatic logic [EXP_W-1:0] exp_rom_entry(input int idx, input int depth);
        longint    r;
        longint    v;
        exp_norm_t nrm;
        int        sh;
        r   = div_trunc(longint'(idx) * ONE_Q30, longint'(depth)) - ONE_Q30 / 2;
        nrm = exp_build(r, 4);
        sh  = nrm.ex - 10;
        if (sh >= 0) begin
            v = nrm.mant << sh;
        end else if (-sh >= 63) begin
            v = 0;
        end else begin
            v = (nrm.mant + (longint'(1) << (-sh - 1))) >> (-sh);
        end
        return v[EXP_W-1:0];
    endfunction

    // sigmoid table entry, Q0.16 of 1 / (1 + exp(16 - 32 idx / depth))
    function automatic logic [SCORE_W-1:0] sig_rom_entry(input int idx, input int depth);
        longint    r;
        longint    v;
        longint    den;
        longint    s;
        exp_norm_t nrm;
        r   = ONE_Q30 / 2 - div_trunc(longint'(idx) * ONE_Q30, longint'(depth));
        nrm = exp_build(r, 5);
        if (nrm.ex >= 0) begin
            v = nrm.mant << nrm.ex;
        end else if (-nrm.ex >= 63) begin
            v = 0;
        end else begin
            v = nrm.mant >> (-nrm.ex);
        end
        den = ONE_Q30 + v;
        s   = div_trunc((longint'(1) << 46) + (den >>> 1), den);
        if (s > 65535) begin
            s = 65535;
        end
        return s[SCORE_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ssdbd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdbd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ssdbd_cfg
    import ssdbd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LOGIT_THRESHOLD: cfg_next.logit_threshold = $signed(cfg_data);
                CFG_NUM_CLASSES:     cfg_next.num_classes     = cfg_data[CLASS_W-1:0];
                CFG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[SIZE_W-1:0];
                CFG_CENTER_WEIGHT:   cfg_next.center_weight   = cfg_data[WEIGHT_W-1:0];
                CFG_SIZE_WEIGHT:     cfg_next.size_weight     = cfg_data[WEIGHT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ssdbd_exp_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdbd_exp_rom
// Exponential lookup table in Q12.20 with a registered read port.
// ----------------------------------------------------------------------------
module ssdbd_exp_rom
    import ssdbd_pkg::*;
#(
    parameter  int DEPTH = EXP_TABLE_DEPTH_DEF,
    localparam int IW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic [IW-1:0]    rd_index,
    output logic      [EXP_W-1:0] rd_data
);

    logic [EXP_W-1:0] rom [DEPTH];
    logic [EXP_W-1:0] rd_data_reg;

    // table contents, fixed at elaboration
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [EXP_W-1:0] ENTRY = exp_rom_entry(g, DEPTH);
        assign rom[g] = ENTRY;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom[rd_index];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ssdbd_sig_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdbd_sig_rom
// Sigmoid lookup table in Q0.16 with a registered read port.
// ----------------------------------------------------------------------------
module ssdbd_sig_rom
    import ssdbd_pkg::*;
#(
    parameter  int DEPTH = SIG_TABLE_DEPTH_DEF,
    localparam int IW    = $clog2(DEPTH)
)
(
    input  wire logic               clk,
    input  wire logic [IW-1:0]      rd_index,
    output logic      [SCORE_W-1:0] rd_data
);

    logic [SCORE_W-1:0] rom [DEPTH];
    logic [SCORE_W-1:0] rd_data_reg;

    // table contents, fixed at elaboration
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [SCORE_W-1:0] ENTRY = sig_rom_entry(g, DEPTH);
        assign rom[g] = ENTRY;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom[rd_index];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ssdbd_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssdbd_pixel
// Two stage scaling of one Q.24 edge to Q15.4 pixels, round half up and
// saturate to the 20 bit range.
// ----------------------------------------------------------------------------
module ssdbd_pixel
    import ssdbd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [Q24_W-1:0] coord_q24,
    input  wire logic [SIZE_W-1:0]       img_size,
    output logic signed [BOX_W-1:0]      pixel
);

    localparam int PW = Q24_W + SIZE_W + 1;
    localparam int SW = PW + 1 - 20;

    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW:0]      rnd;
    logic signed [SW-1:0]    shifted;
    logic signed [BOX_W-1:0] pixel_reg;
    logic signed [BOX_W-1:0] pixel_next;

    // edge times image size
    always_comb
    begin
        prod_next = PW'(coord_q24) * PW'($signed({1'b0, img_size}));
    end

    // round half up, floor to Q.4, saturate
    always_comb
    begin
        rnd     = (PW + 1)'(prod_reg) + $signed((PW + 1)'(1 << 19));
        shifted = rnd[PW:20];
        if ((shifted[SW-1:BOX_W-1] == '0) || (shifted[SW-1:BOX_W-1] == '1))
        begin
            pixel_next = shifted[BOX_W-1:0];
        end
        else if (shifted[SW-1])
        begin
            pixel_next = {1'b1, {(BOX_W - 1){1'b0}}};
        end
        else
        begin
            pixel_next = {1'b0, {(BOX_W - 1){1'b1}}};
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ssd_box_decode_threshold.sv
`default_nettype none
// Throughput: one word per clock; busy stays low, seven register stages run
// back to back; sigmoid read in stage two, two exp table reads in stage three.
// Words that fail the class or logit gate drop out at the first stage.
// Reset clears the valid pipeline and loads the register defaults; the lookup
// tables are constant, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// ssd_box_decode_threshold
// SSD anchor box decoder with a class gate: center and size decode, exp and
// sigmoid lookup, pixel scaling with saturation.
// ----------------------------------------------------------------------------
module ssd_box_decode_threshold
    import ssdbd_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH     = EXP_TABLE_DEPTH_DEF,
    parameter int SIGMOID_TABLE_DEPTH = SIG_TABLE_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [DELTA_W-1:0] delta_y,
    input  wire logic signed [DELTA_W-1:0] delta_x,
    input  wire logic signed [DELTA_W-1:0] delta_h,
    input  wire logic signed [DELTA_W-1:0] delta_w,
    input  wire logic [PRIOR_W-1:0]        prior_center_x,
    input  wire logic [PRIOR_W-1:0]        prior_center_y,
    input  wire logic [PRIOR_W-1:0]        prior_width,
    input  wire logic [PRIOR_W-1:0]        prior_height,
    input  wire logic [CLASS_W-1:0]        class_index,
    input  wire logic signed [LOGIT_W-1:0] class_logit,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                           done,
    output logic signed [BOX_W-1:0]        box_xmin,
    output logic signed [BOX_W-1:0]        box_ymin,
    output logic signed [BOX_W-1:0]        box_xmax,
    output logic signed [BOX_W-1:0]        box_ymax,
    output logic [CLASS_W-1:0]             label,
    output logic [SCORE_W-1:0]             score
);

    localparam int EIW = $clog2(EXP_TABLE_DEPTH);
    localparam int EPW = EIW + 33;
    localparam int SIW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int SPW = SIW + 17;
    localparam int LAT = 7;

    cfg_t cfg;

    // exp table index from delta times size weight, Q.28 plus 8 scaled to depth
    function automatic logic [EIW-1:0] exp_index(input logic signed [PROD_W-1:0] a);
        logic [PROD_W-1:0] t;
        logic [EPW-1:0]    prod;
        logic [EIW:0]      wide;
        // operand range keeps a above -2^31, so adding 2^31 flips the sign bit
        t    = {~a[PROD_W-1], a[PROD_W-2:0]};
        prod = EPW'(t) * EPW'(EXP_TABLE_DEPTH);
        wide = prod[EPW-1:32];
        if (wide > (EIW + 1)'(EXP_TABLE_DEPTH - 1))
        begin
            return EIW'(EXP_TABLE_DEPTH - 1);
        end
        return wide[EIW-1:0];
    endfunction

    // configuration registers
    ssdbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // every cycle takes a word
    assign busy = 1'b0;

    // stage 0: class gate, weighted deltas, sigmoid index
    logic                        gate_pass;
    logic [LAT-1:0]              valid_reg;
    logic [LAT-1:0]              valid_next;
    logic signed [PROD_W:0]      prod_cx;
    logic signed [PROD_W:0]      prod_cy;
    logic signed [PROD_W:0]      prod_aw;
    logic signed [PROD_W:0]      prod_ah;
    logic signed [LOGIT_W:0]     logit_ofs;
    logic [LOGIT_W-1:0]          sig_t;
    logic [SPW-1:0]              sig_prod;
    logic [SIW+3:0]              sig_wide;
    logic [SIW-1:0]              s1_sidx_next;

    always_comb
    begin
        gate_pass = (class_index != '0) && (class_index < cfg.num_classes)
                    && ($signed(class_logit) > $signed(cfg.logit_threshold));
        valid_next = {valid_reg[LAT-2:0], start && !busy && gate_pass};

        prod_cx = $signed(delta_x) * $signed({1'b0, cfg.center_weight});
        prod_cy = $signed(delta_y) * $signed({1'b0, cfg.center_weight});
        prod_aw = $signed(delta_w) * $signed({1'b0, cfg.size_weight});
        prod_ah = $signed(delta_h) * $signed({1'b0, cfg.size_weight});

        logit_ofs = (LOGIT_W + 1)'($signed(class_logit)) + 17'sd4096;
        sig_t     = logit_ofs[LOGIT_W] ? '0 : logit_ofs[LOGIT_W-1:0];
        sig_prod  = SPW'(sig_t) * SPW'(SIGMOID_TABLE_DEPTH);
        sig_wide  = sig_prod[SPW-1:13];
        if (sig_wide > (SIW + 4)'(SIGMOID_TABLE_DEPTH - 1))
        begin
            s1_sidx_next = SIW'(SIGMOID_TABLE_DEPTH - 1);
        end
        else
        begin
            s1_sidx_next = sig_wide[SIW-1:0];
        end
    end

    // stage 1 registers
    logic signed [PROD_W-1:0] s1_pcx_reg;
    logic signed [PROD_W-1:0] s1_pcy_reg;
    logic signed [PROD_W-1:0] s1_aw_reg;
    logic signed [PROD_W-1:0] s1_ah_reg;
    logic [PRIOR_W-1:0]       s1_cx_reg;
    logic [PRIOR_W-1:0]       s1_cy_reg;
    logic [PRIOR_W-1:0]       s1_pw_reg;
    logic [PRIOR_W-1:0]       s1_ph_reg;
    logic [CLASS_W-1:0]       s1_cls_reg;
    logic [SIW-1:0]           s1_sidx_reg;

    always_ff @(posedge clk)
    begin
        s1_pcx_reg  <= prod_cx[PROD_W-1:0];
        s1_pcy_reg  <= prod_cy[PROD_W-1:0];
        s1_aw_reg   <= prod_aw[PROD_W-1:0];
        s1_ah_reg   <= prod_ah[PROD_W-1:0];
        s1_cx_reg   <= prior_center_x;
        s1_cy_reg   <= prior_center_y;
        s1_pw_reg   <= prior_width;
        s1_ph_reg   <= prior_height;
        s1_cls_reg  <= class_index;
        s1_sidx_reg <= s1_sidx_next;
    end

    // stage 2: centers in Q.44, exp indexes, sigmoid read
    logic signed [CENTER_W-1:0] s2_cx_next;
    logic signed [CENTER_W-1:0] s2_cy_next;
    logic signed [CENTER_W-1:0] s2_cx_reg;
    logic signed [CENTER_W-1:0] s2_cy_reg;
    logic [EIW-1:0]             s2_widx_next;
    logic [EIW-1:0]             s2_hidx_next;
    logic [PRIOR_W-1:0]         s2_pw_reg;
    logic [PRIOR_W-1:0]         s2_ph_reg;
    logic [CLASS_W-1:0]         s2_cls_reg;
    logic [SCORE_W-1:0]         s2_score;

    always_comb
    begin
        s2_cx_next = CENTER_W'(s1_pcx_reg) * CENTER_W'($signed({1'b0, s1_pw_reg}))
                     + $signed({5'b0, s1_cx_reg, 28'b0});
        s2_cy_next = CENTER_W'(s1_pcy_reg) * CENTER_W'($signed({1'b0, s1_ph_reg}))
                     + $signed({5'b0, s1_cy_reg, 28'b0});
        s2_widx_next = exp_index(s1_aw_reg);
        s2_hidx_next = exp_index(s1_ah_reg);
    end

    ssdbd_sig_rom #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sig_rom (
        .clk      (clk),
        .rd_index (s1_sidx_reg),
        .rd_data  (s2_score)
    );

    logic [EIW-1:0] s2_widx_reg;
    logic [EIW-1:0] s2_hidx_reg;

    always_ff @(posedge clk)
    begin
        s2_cx_reg   <= s2_cx_next;
        s2_cy_reg   <= s2_cy_next;
        s2_widx_reg <= s2_widx_next;
        s2_hidx_reg <= s2_hidx_next;
        s2_pw_reg   <= s1_pw_reg;
        s2_ph_reg   <= s1_ph_reg;
        s2_cls_reg  <= s1_cls_reg;
    end

    // stage 3: exp table reads
    logic [EXP_W-1:0]           s3_expw;
    logic [EXP_W-1:0]           s3_exph;
    logic signed [CENTER_W-1:0] s3_cx_reg;
    logic signed [CENTER_W-1:0] s3_cy_reg;
    logic [PRIOR_W-1:0]         s3_pw_reg;
    logic [PRIOR_W-1:0]         s3_ph_reg;
    logic [CLASS_W-1:0]         s3_cls_reg;
    logic [SCORE_W-1:0]         s3_score_reg;

    ssdbd_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom_w (
        .clk      (clk),
        .rd_index (s2_widx_reg),
        .rd_data  (s3_expw)
    );

    ssdbd_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom_h (
        .clk      (clk),
        .rd_index (s2_hidx_reg),
        .rd_data  (s3_exph)
    );

    always_ff @(posedge clk)
    begin
        s3_cx_reg    <= s2_cx_reg;
        s3_cy_reg    <= s2_cy_reg;
        s3_pw_reg    <= s2_pw_reg;
        s3_ph_reg    <= s2_ph_reg;
        s3_cls_reg   <= s2_cls_reg;
        s3_score_reg <= s2_score;
    end

    // stage 4: half sizes, exp entry times prior
    logic [HALF_W-1:0]          s4_hw_next;
    logic [HALF_W-1:0]          s4_hh_next;
    logic [HALF_W-1:0]          s4_hw_reg;
    logic [HALF_W-1:0]          s4_hh_reg;
    logic signed [CENTER_W-1:0] s4_cx_reg;
    logic signed [CENTER_W-1:0] s4_cy_reg;
    logic [CLASS_W-1:0]         s4_cls_reg;
    logic [SCORE_W-1:0]         s4_score_reg;

    always_comb
    begin
        s4_hw_next = HALF_W'(s3_expw) * HALF_W'(s3_pw_reg);
        s4_hh_next = HALF_W'(s3_exph) * HALF_W'(s3_ph_reg);
    end

    always_ff @(posedge clk)
    begin
        s4_hw_reg    <= s4_hw_next;
        s4_hh_reg    <= s4_hh_next;
        s4_cx_reg    <= s3_cx_reg;
        s4_cy_reg    <= s3_cy_reg;
        s4_cls_reg   <= s3_cls_reg;
        s4_score_reg <= s3_score_reg;
    end

    // stage 5: corner edges, floored to Q.24
    logic signed [Q44_W-1:0] hw_q44;
    logic signed [Q44_W-1:0] hh_q44;
    logic signed [Q44_W-1:0] cx_q44;
    logic signed [Q44_W-1:0] cy_q44;
    logic signed [Q44_W-1:0] xmin_q44;
    logic signed [Q44_W-1:0] ymin_q44;
    logic signed [Q44_W-1:0] xmax_q44;
    logic signed [Q44_W-1:0] ymax_q44;
    logic signed [Q24_W-1:0] s5_xmin_reg;
    logic signed [Q24_W-1:0] s5_ymin_reg;
    logic signed [Q24_W-1:0] s5_xmax_reg;
    logic signed [Q24_W-1:0] s5_ymax_reg;
    logic [CLASS_W-1:0]      s5_cls_reg;
    logic [SCORE_W-1:0]      s5_score_reg;

    always_comb
    begin
        hw_q44   = $signed({2'b0, s4_hw_reg, 7'b0});
        hh_q44   = $signed({2'b0, s4_hh_reg, 7'b0});
        cx_q44   = Q44_W'(s4_cx_reg);
        cy_q44   = Q44_W'(s4_cy_reg);
        xmin_q44 = cx_q44 - hw_q44;
        ymin_q44 = cy_q44 - hh_q44;
        xmax_q44 = cx_q44 + hw_q44;
        ymax_q44 = cy_q44 + hh_q44;
    end

    always_ff @(posedge clk)
    begin
        s5_xmin_reg  <= xmin_q44[Q44_W-1:20];
        s5_ymin_reg  <= ymin_q44[Q44_W-1:20];
        s5_xmax_reg  <= xmax_q44[Q44_W-1:20];
        s5_ymax_reg  <= ymax_q44[Q44_W-1:20];
        s5_cls_reg   <= s4_cls_reg;
        s5_score_reg <= s4_score_reg;
    end

    // stages 6 and 7: pixel scaling
    ssdbd_pixel u_pix_xmin (
        .clk       (clk),
        .coord_q24 (s5_xmin_reg),
        .img_size  (cfg.image_width),
        .pixel     (box_xmin)
    );

    ssdbd_pixel u_pix_ymin (
        .clk       (clk),
        .coord_q24 (s5_ymin_reg),
        .img_size  (cfg.image_height),
        .pixel     (box_ymin)
    );

    ssdbd_pixel u_pix_xmax (
        .clk       (clk),
        .coord_q24 (s5_xmax_reg),
        .img_size  (cfg.image_width),
        .pixel     (box_xmax)
    );

    ssdbd_pixel u_pix_ymax (
        .clk       (clk),
        .coord_q24 (s5_ymax_reg),
        .img_size  (cfg.image_height),
        .pixel     (box_ymax)
    );

    // label and score follow the pixel stages
    logic [CLASS_W-1:0] s6_cls_reg;
    logic [SCORE_W-1:0] s6_score_reg;
    logic [CLASS_W-1:0] label_reg;
    logic [SCORE_W-1:0] score_reg;

    always_ff @(posedge clk)
    begin
        s6_cls_reg   <= s5_cls_reg;
        s6_score_reg <= s5_score_reg;
        label_reg    <= s6_cls_reg;
        score_reg    <= s6_score_reg;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done  = valid_reg[LAT-1];
    assign label = label_reg;
    assign score = score_reg;

`ifndef ASSERT_OFF
    // background never leaves the block
    a_no_background: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (label != '0))
        else $error("background class produced a result word");

    // a gated word produces no result
    a_gated_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((class_index == '0) || (class_index >= cfg.num_classes)
            || ($signed(class_logit) <= $signed(cfg.logit_threshold))))
        |-> ##7 !done)
        else $error("gated word produced a result word");

    // a passing word always reaches the output after the pipeline latency
    a_pass_reaches: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (class_index != '0) && (class_index < cfg.num_classes)
            && ($signed(class_logit) > $signed(cfg.logit_threshold)))
        |-> ##7 (done && (label == $past(class_index, 7))))
        else $error("passing word lost or mislabeled in the pipeline");
`endif

endmodule
`default_nettype wire

FILE: sim/ssd_box_decode_threshold_tb.sv
// ----------------------------------------------------------------------------
// ssd_box_decode_threshold_tb
// Self-checking bench for the SSD box decoder with class gate. A scoreboard
// rebuilds the exp and sigmoid tables, mirrors the register writes and works
// out the detection for every passing anchor word; each done strobe is
// compared field by field with the oldest pending detection. Stimulus is a
// short directed set followed by random phases over several register
// settings and sender idle rates.
// ----------------------------------------------------------------------------
import ssdbd_pkg::*;

// one anchor word as driven on the input ports
typedef struct {
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dh;
    logic signed [DELTA_W-1:0] dw;
    logic [PRIOR_W-1:0]        pcx;
    logic [PRIOR_W-1:0]        pcy;
    logic [PRIOR_W-1:0]        pw;
    logic [PRIOR_W-1:0]        ph;
    logic [CLASS_W-1:0]        cls;
    logic signed [LOGIT_W-1:0] logit;
} anchor_word_t;

// one decoded detection
typedef struct {
    logic signed [BOX_W-1:0] box_xmin;
    logic signed [BOX_W-1:0] box_ymin;
    logic signed [BOX_W-1:0] box_xmax;
    logic signed [BOX_W-1:0] box_ymax;
    logic [CLASS_W-1:0]      label;
    logic [SCORE_W-1:0]      score;
} detection_t;

class detection_scoreboard;

    longint     exp_table [EXP_TABLE_DEPTH_DEF];
    longint     sig_table [SIG_TABLE_DEPTH_DEF];
    longint     thr;
    int         nc;
    longint     iw;
    longint     ih;
    longint     cw;
    longint     sw;
    detection_t pending [$];
    int         mismatches;

    function new();
        longint unsigned m;
        longint unsigned v;
        longint unsigned den;
        longint unsigned s;
        longint          r;
        int              e;
        int              sh;
        // exp table, Q12.20 of exp(-8 + 16 i / depth)
        for (int i = 0; i < EXP_TABLE_DEPTH_DEF; i++)
        begin
            r = (longint'(i) * ONE_Q30) / EXP_TABLE_DEPTH_DEF - ONE_Q30 / 2;
            exp_norm(r, 4, m, e);
            sh = e - 10;
            if (sh >= 0)
                v = m << sh;
            else if (-sh >= 63)
                v = 0;
            else
                v = (m + (64'd1 << (-sh - 1))) >> (-sh);
            exp_table[i] = longint'(v[31:0]);
        end
        // sigmoid table, Q0.16 of 1 / (1 + exp(16 - 32 i / depth))
        for (int i = 0; i < SIG_TABLE_DEPTH_DEF; i++)
        begin
            r = ONE_Q30 / 2 - (longint'(i) * ONE_Q30) / SIG_TABLE_DEPTH_DEF;
            exp_norm(r, 5, m, e);
            if (e >= 0)
                v = m << e;
            else if (-e >= 63)
                v = 0;
            else
                v = m >> (-e);
            den = 64'd1073741824 + v;
            s = ((64'd1 << 46) + den / 2) / den;
            if (s > 65535)
                s = 65535;
            sig_table[i] = longint'(s);
        end
        thr = longint'(CFG_RESET.logit_threshold);
        nc  = int'(CFG_RESET.num_classes);
        iw  = longint'(CFG_RESET.image_width);
        ih  = longint'(CFG_RESET.image_height);
        cw  = longint'(CFG_RESET.center_weight);
        sw  = longint'(CFG_RESET.size_weight);
        mismatches = 0;
    endfunction

    // taylor series then repeated squaring, mantissa Q.30 in [1,2) times 2^e
    function void exp_norm(input longint r, input int squarings,
                           output longint unsigned m, output int e);
        longint term;
        longint sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        e    = 0;
        for (int n = 1; n <= 17; n++)
        begin
            term = (term * r) / ONE_Q30;
            term = term / longint'(n);
            sum  = sum + term;
        end
        m = longint'(sum);
        if (m < (64'd1 << 30))
        begin
            m = m << 1;
            e = e - 1;
        end
        if (m >= (64'd1 << 31))
        begin
            m = (m + 1) >> 1;
            e = e + 1;
        end
        for (int n = 0; n < squarings; n++)
        begin
            m = (m * m + (64'd1 << 29)) >> 30;
            e = e * 2;
            if (m >= (64'd1 << 31))
            begin
                m = (m + 1) >> 1;
                e = e + 1;
            end
        end
    endfunction

    function void set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_LOGIT_THRESHOLD: thr = longint'(signed'(v));
            CFG_NUM_CLASSES:     nc  = int'(v[CLASS_W-1:0]);
            CFG_IMAGE_WIDTH:     iw  = longint'(v[SIZE_W-1:0]);
            CFG_IMAGE_HEIGHT:    ih  = longint'(v[SIZE_W-1:0]);
            CFG_CENTER_WEIGHT:   cw  = longint'(v);
            CFG_SIZE_WEIGHT:     sw  = longint'(v);
            default: ;
        endcase
    endfunction

    // half box extent in Q.44 from the exp table
    function longint half_extent(input logic signed [DELTA_W-1:0] d,
                                 input logic [PRIOR_W-1:0] prior);
        longint t;
        longint idx;
        t = longint'(d) * sw + (longint'(1) << 31);
        if (t < 0)
            t = 0;
        idx = (t * EXP_TABLE_DEPTH_DEF) >>> 32;
        if (idx > EXP_TABLE_DEPTH_DEF - 1)
            idx = EXP_TABLE_DEPTH_DEF - 1;
        return (exp_table[idx] * longint'(prior)) <<< 7;
    endfunction

    // Q.44 fraction to Q.4 pixels, floor to Q.24, round half up, saturate
    function logic signed [BOX_W-1:0] to_pixels(input longint c44, input longint size);
        longint c24;
        longint p;
        c24 = c44 >>> 20;
        p = (c24 * size + (longint'(1) << 19)) >>> 20;
        if (p > 524287)
            p = 524287;
        if (p < -524288)
            p = -524288;
        return p[BOX_W-1:0];
    endfunction

    function void note_word(input anchor_word_t w);
        detection_t d;
        longint     cx;
        longint     cy;
        longint     hw;
        longint     hh;
        longint     t;
        // class and logit gate
        if (w.cls == 0 || int'(w.cls) >= nc || longint'(w.logit) <= thr)
            return;
        cx = longint'(w.dx) * cw * longint'(w.pw) + (longint'(w.pcx) <<< 28);
        cy = longint'(w.dy) * cw * longint'(w.ph) + (longint'(w.pcy) <<< 28);
        hw = half_extent(w.dw, w.pw);
        hh = half_extent(w.dh, w.ph);
        d.box_xmin = to_pixels(cx - hw, iw);
        d.box_ymin = to_pixels(cy - hh, ih);
        d.box_xmax = to_pixels(cx + hw, iw);
        d.box_ymax = to_pixels(cy + hh, ih);
        d.label    = w.cls;
        // sigmoid lookup, index saturates at both ends
        t = longint'(w.logit) + 4096;
        if (t < 0)
            t = 0;
        t = (t * SIG_TABLE_DEPTH_DEF) >>> 13;
        if (t > SIG_TABLE_DEPTH_DEF - 1)
            t = SIG_TABLE_DEPTH_DEF - 1;
        d.score = sig_table[t][SCORE_W-1:0];
        pending.push_back(d);
    endfunction

    function void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function void check_result(input detection_t got);
        detection_t want;
        if (pending.size() == 0)
        begin
            note_failure($sformatf("unexpected detection: box %0d %0d %0d %0d label %0d score %0d",
                got.box_xmin, got.box_ymin, got.box_xmax, got.box_ymax,
                got.label, got.score));
            return;
        end
        want = pending.pop_front();
        if (got.box_xmin !== want.box_xmin || got.box_ymin !== want.box_ymin ||
            got.box_xmax !== want.box_xmax || got.box_ymax !== want.box_ymax ||
            got.label !== want.label || got.score !== want.score)
            note_failure($sformatf(
                "detection mismatch: expected box %0d %0d %0d %0d label %0d score %0d, got box %0d %0d %0d %0d label %0d score %0d",
                want.box_xmin, want.box_ymin, want.box_xmax, want.box_ymax,
                want.label, want.score, got.box_xmin, got.box_ymin,
                got.box_xmax, got.box_ymax, got.label, got.score));
    endfunction

endclass

module ssd_box_decode_threshold_tb;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_h;
    logic signed [DELTA_W-1:0] delta_w;
    logic [PRIOR_W-1:0]        prior_center_x;
    logic [PRIOR_W-1:0]        prior_center_y;
    logic [PRIOR_W-1:0]        prior_width;
    logic [PRIOR_W-1:0]        prior_height;
    logic [CLASS_W-1:0]        class_index;
    logic signed [LOGIT_W-1:0] class_logit;
    logic                      cfg_write;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      done;
    logic signed [BOX_W-1:0]   box_xmin;
    logic signed [BOX_W-1:0]   box_ymin;
    logic signed [BOX_W-1:0]   box_xmax;
    logic signed [BOX_W-1:0]   box_ymax;
    logic [CLASS_W-1:0]        label;
    logic [SCORE_W-1:0]        score;

    detection_scoreboard sb;

    ssd_box_decode_threshold i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .delta_y        (delta_y),
        .delta_x        (delta_x),
        .delta_h        (delta_h),
        .delta_w        (delta_w),
        .prior_center_x (prior_center_x),
        .prior_center_y (prior_center_y),
        .prior_width    (prior_width),
        .prior_height   (prior_height),
        .class_index    (class_index),
        .class_logit    (class_logit),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .box_xmin       (box_xmin),
        .box_ymin       (box_ymin),
        .box_xmax       (box_xmax),
        .box_ymax       (box_ymax),
        .label          (label),
        .score          (score)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    // sample results, register writes and accepted words at the rising edge
    always @(posedge clk)
    begin : monitor
        detection_t   got;
        anchor_word_t w;
        if (rst_n)
        begin
            if (done)
            begin
                got.box_xmin = box_xmin;
                got.box_ymin = box_ymin;
                got.box_xmax = box_xmax;
                got.box_ymax = box_ymax;
                got.label    = label;
                got.score    = score;
                sb.check_result(got);
            end
            if (cfg_write)
                sb.set_reg(cfg_index, cfg_data);
            if (start && !busy)
            begin
                w.dy    = delta_y;
                w.dx    = delta_x;
                w.dh    = delta_h;
                w.dw    = delta_w;
                w.pcx   = prior_center_x;
                w.pcy   = prior_center_y;
                w.pw    = prior_width;
                w.ph    = prior_height;
                w.cls   = class_index;
                w.logit = class_logit;
                sb.note_word(w);
            end
        end
    end

    function automatic anchor_word_t mk(input int dy, input int dx, input int dh,
                                        input int dw, input int pcx, input int pcy,
                                        input int pw, input int ph, input int cls,
                                        input int logit);
        anchor_word_t w;
        w.dy    = 16'(dy);
        w.dx    = 16'(dx);
        w.dh    = 16'(dh);
        w.dw    = 16'(dw);
        w.pcx   = 16'(pcx);
        w.pcy   = 16'(pcy);
        w.pw    = 16'(pw);
        w.ph    = 16'(ph);
        w.cls   = 8'(cls);
        w.logit = 16'(logit);
        return w;
    endfunction

    // half full range, half small deltas near zero
    function automatic logic signed [DELTA_W-1:0] rand_delta();
        if ($urandom_range(1) == 1)
            return 16'($urandom());
        return 16'(int'($urandom_range(8191)) - 4096);
    endfunction

    // mostly words that pass the gate, the rest background, out of range or weak
    function automatic anchor_word_t random_word();
        anchor_word_t w;
        int           lo;
        int           span;
        w.dy  = rand_delta();
        w.dx  = rand_delta();
        w.dh  = rand_delta();
        w.dw  = rand_delta();
        w.pcx = 16'($urandom());
        w.pcy = 16'($urandom());
        w.pw  = 16'($urandom());
        w.ph  = 16'($urandom());
        if ($urandom_range(99) < 75 && sb.nc >= 2 && sb.thr < 32767)
        begin
            w.cls = 8'($urandom_range(sb.nc - 1, 1));
            lo    = int'(sb.thr) + 1;
            span  = 32767 - lo;
            if ($urandom_range(1) == 1 && span > 2047)
                span = 2047;
            w.logit = 16'(lo + int'($urandom_range(span)));
        end
        else
        begin
            w.cls   = 8'($urandom());
            w.logit = 16'($urandom());
            case ($urandom_range(3))
                0: w.cls = 8'd0;
                1: w.cls = 8'($urandom_range(255, sb.nc));
                2: w.logit = 16'(int'(sb.thr) - int'($urandom_range(int'(sb.thr) + 32768)));
                default: ;
            endcase
        end
        return w;
    endfunction

    // present one word and hold it until the block takes it
    task automatic drive_word(input anchor_word_t w);
        start          <= 1'b1;
        delta_y        <= w.dy;
        delta_x        <= w.dx;
        delta_h        <= w.dh;
        delta_w        <= w.dw;
        prior_center_x <= w.pcx;
        prior_center_y <= w.pcy;
        prior_width    <= w.pw;
        prior_height   <= w.ph;
        class_index    <= w.cls;
        class_logit    <= w.logit;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending until every pending detection is out and the pipe is empty
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
    endtask

    task automatic program_regs(input int thr, input int nc, input int iw, input int ih,
                                input int cw, input int sw);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_LOGIT_THRESHOLD;
        cfg_data  <= 16'(thr);
        @(negedge clk);
        cfg_index <= CFG_NUM_CLASSES;
        cfg_data  <= 16'(nc);
        @(negedge clk);
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= 16'(iw);
        @(negedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= 16'(ih);
        @(negedge clk);
        cfg_index <= CFG_CENTER_WEIGHT;
        cfg_data  <= 16'(cw);
        @(negedge clk);
        cfg_index <= CFG_SIZE_WEIGHT;
        cfg_data  <= 16'(sw);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // random words with a sender idle rate, optionally a full drain halfway
    task automatic random_words(input int count, input int idle_pct, input bit pause_mid);
        for (int n = 0; n < count; n++)
        begin
            if (pause_mid && n == count / 2)
                drain();
            while (int'($urandom_range(99)) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            drive_word(random_word());
        end
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        delta_y        = '0;
        delta_x        = '0;
        delta_h        = '0;
        delta_w        = '0;
        prior_center_x = '0;
        prior_center_y = '0;
        prior_width    = '0;
        prior_height   = '0;
        class_index    = '0;
        class_logit    = '0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_LOGIT_THRESHOLD;
        cfg_data       = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words under the reset register values
        drive_word(mk(0, 0, 0, 0, 32768, 32768, 13107, 13107, 1, 256));
        drive_word(mk(100, -100, 50, -50, 30000, 40000, 20000, 10000, 0, 1000));
        drive_word(mk(-4096, 4096, 4096, -4096, 1000, 64000, 5000, 60000, 90, 1));
        drive_word(mk(0, 0, 0, 0, 32768, 32768, 13107, 13107, 91, 1000));
        drive_word(mk(0, 0, 0, 0, 32768, 32768, 13107, 13107, 255, 1000));
        drive_word(mk(0, 0, 0, 0, 32768, 32768, 13107, 13107, 3, 0));
        drive_word(mk(0, 0, 0, 0, 32768, 32768, 13107, 13107, 3, -32768));
        drive_word(mk(12, -34, 56, -78, 1234, 4321, 9999, 8888, 5, 32767));
        drive_word(mk(32767, 32767, 32767, 32767, 65535, 65535, 65535, 65535, 7, 500));
        drive_word(mk(-32768, -32768, -32768, -32768, 0, 0, 0, 0, 8, 600));
        drive_word(mk(-32768, -32768, -32768, -32768, 65535, 65535, 65535, 65535, 9, 700));
        drive_word(mk(32767, -32768, -32768, 32767, 1, 1, 1, 1, 89, 4096));

        // widest gate, largest image and weights: huge boxes and low logits
        program_regs(-32768, 255, 4095, 4095, 65535, 65535);
        drive_word(mk(32767, 32767, 32767, 32767, 65535, 65535, 65535, 65535, 254, -32767));
        drive_word(mk(-32768, -32768, 32767, 32767, 0, 0, 65535, 65535, 254, -4097));
        drive_word(mk(0, 0, -32768, -32768, 65535, 0, 65535, 65535, 1, -4096));
        drive_word(mk(1, -1, 0, 0, 32768, 32768, 100, 100, 200, 4095));
        random_words(320, 0, 1'b0);

        // narrowest settings, sender mostly idle
        program_regs(256, 2, 1, 1, 0, 0);
        random_words(300, 70, 1'b0);

        // default coder, back to back with a full pause halfway
        program_regs(-512, 91, 300, 300, 6554, 13107);
        random_words(400, 0, 1'b1);

        // gate at its top: nothing can pass
        program_regs(32767, 255, 640, 480, 6554, 13107);
        random_words(40, 33, 1'b0);

        // zero image size flattens every edge
        program_regs(-1024, 100, 0, 0, 30000, 20000);
        random_words(150, 33, 1'b0);

        // a single class leaves nothing but background
        program_regs(0, 1, 300, 300, 6554, 13107);
        random_words(30, 70, 1'b0);

        // random settings across the idle rates
        for (int k = 0; k < 3; k++)
        begin
            program_regs(int'($urandom_range(4000)) - 2000, int'($urandom_range(255, 2)),
                         int'($urandom_range(4095, 1)), int'($urandom_range(4095, 1)),
                         int'($urandom_range(65535)), int'($urandom_range(65535)));
            random_words(220, (k == 1) ? 70 : ((k == 2) ? 33 : 0), k == 0);
        end

        // let the pipeline run dry
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (sb.pending.size() != 0)
            $display("detections never produced: %0d", sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ssdbd_pkg.sv
hw/rtl/ssdbd_cfg.sv
hw/rtl/ssdbd_exp_rom.sv
hw/rtl/ssdbd_sig_rom.sv
hw/rtl/ssdbd_pixel.sv
hw/rtl/ssd_box_decode_threshold.sv
sim/ssd_box_decode_threshold_tb.sv
